FILE: rtl/core/blft_pkg.sv
`default_nettype none

package blft_pkg;

    localparam int BUFFER_DEPTH_DEF = 32;

    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_START_BYTE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_END_BYTE    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ID   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_STATUS_ID   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_ID     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_VOLT_ID     = 3'd5;

    localparam logic [7:0] START_BYTE_RST = 8'd172;
    localparam logic [7:0] END_BYTE_RST   = 8'd173;
    localparam logic [7:0] DEVICE_ID_RST  = 8'd128;
    localparam logic [7:0] STATUS_ID_RST  = 8'd4;
    localparam logic [7:0] TEMP_ID_RST    = 8'd5;
    localparam logic [7:0] VOLT_ID_RST    = 8'd6;

    localparam logic [7:0] SYNC_BYTE = 8'hFF;

    localparam logic [0:0] OP_RX_BYTE = 1'b0;
    localparam logic [0:0] OP_SEND    = 1'b1;

    localparam logic [1:0] KIND_TX        = 2'd0;
    localparam logic [1:0] KIND_WORD      = 2'd1;
    localparam logic [1:0] KIND_CRC_ERR   = 2'd2;
    localparam logic [1:0] KIND_FRAME_ERR = 2'd3;

    localparam logic [1:0] MK_STATUS = 2'd0;
    localparam logic [1:0] MK_TEMPS  = 2'd1;
    localparam logic [1:0] MK_CELLS  = 2'd2;

    localparam logic [2:0] TX_POS_SYNC0 = 3'd0;
    localparam logic [2:0] TX_POS_START = 3'd1;
    localparam logic [2:0] TX_POS_DEV   = 3'd2;
    localparam logic [2:0] TX_POS_ID    = 3'd3;
    localparam logic [2:0] TX_POS_CRC   = 3'd4;
    localparam logic [2:0] TX_POS_END   = 3'd5;
    localparam logic [2:0] TX_POS_SYNC1 = 3'd6;

    localparam logic [7:0] CRC_BITS [8] = '{8'h5e, 8'hbc, 8'h61, 8'hc2,
                                            8'h9d, 8'h23, 8'h46, 8'h8c};

    localparam logic [4:0] TEMP_OFFSETS [4] = '{5'd2, 5'd4, 5'd12, 5'd14};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TX_CRC0,
        ST_TX_CRC1,
        ST_TX_SEND,
        ST_CK_RD,
        ST_CK_ACC,
        ST_W_HI,
        ST_W_LO,
        ST_W_CAP,
        ST_W_SEND,
        ST_ERR
    } state_t;

    // One byte step of the reflected CRC-8 (polynomial 0x8C).
    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] x;
        logic [7:0] r;
        x = crc ^ data;
        r = '0;
        for (int k = 0; k < 8; k++) begin
            if (x[k]) begin
                r = r ^ CRC_BITS[k];
            end
        end
        return r;
    endfunction

    function automatic logic [3:0] field_count(input logic [1:0] msg);
        logic [3:0] n;
        case (msg)
            MK_TEMPS: n = 4'd4;
            MK_CELLS: n = 4'd7;
            default:  n = 4'd13;
        endcase
        return n;
    endfunction

    function automatic logic [4:0] word_offset(input logic [1:0] msg, input logic [3:0] idx);
        logic [4:0] off;
        if (msg == MK_TEMPS) begin
            off = TEMP_OFFSETS[idx[1:0]];
        end else begin
            off = 5'd2 + {idx, 1'b0};
        end
        return off;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/battery_link_frame_transceiver.sv
// Send request: CRC work in ST_TX_CRC0 and ST_TX_CRC1, then seven bytes, one per cycle when m_tready is high.
// Received byte: the block stays ready unless the byte ends a frame or overflows the buffer.
// End of frame: a read and an accumulate state per stored byte through the shared CRC step and
// the buffer read port, then high read, low read, capture and send per decoded word, up to 13 words.
// The longest case is 31 stored bytes and 13 words, with s_tready low throughout. Synchronous
// active-low reset clears the sequencer, frame state and message kind, and presets registers.
`default_nettype none

module battery_link_frame_transceiver #(
    parameter int BUFFER_DEPTH = blft_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,    // rx_byte
    input  wire logic [0:0]                       s_tuser,    // opcode
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [31:0]                      m_tdata,    // tx_byte, message_kind,
                                                              // field_index, field_value, pad
    output logic      [1:0]                       m_tuser,    // kind
    output logic                                  m_tlast,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [blft_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]                       cfg_data
);

    import blft_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);

    state_t state_reg, state_next;

    logic [7:0] start_byte_reg, end_byte_reg, device_id_reg;
    logic [7:0] status_id_reg, temp_id_reg, volt_id_reg;

    logic          in_frame_reg, in_frame_next;
    logic [AW-1:0] frame_len_reg, frame_len_next;
    logic [AW-1:0] len_reg, len_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [1:0]    cur_kind_reg, cur_kind_next;
    logic [7:0]    crc_reg, crc_next;
    logic [7:0]    id_reg, id_next;
    logic [15:0]   word_reg, word_next;
    logic [1:0]    err_kind_reg, err_kind_next;

    logic        m_valid_reg, m_valid_next;
    logic [1:0]  m_kind_reg, m_kind_next;
    logic [7:0]  m_tx_reg, m_tx_next;
    logic [1:0]  m_msg_reg, m_msg_next;
    logic [3:0]  m_idx_reg, m_idx_next;
    logic [15:0] m_val_reg, m_val_next;
    logic        m_last_reg, m_last_next;

    logic          accept;
    logic          out_free;
    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    logic [7:0]    crc_operand;
    logic [7:0]    crc_result;
    logic [7:0]    tx_sel;
    logic [3:0]    fld_count;
    logic [AW-1:0] fld_offset;
    logic [1:0]    kind_adv;

    blft_ram #(
        .WIDTH(8),
        .DEPTH(BUFFER_DEPTH)
    ) u_frame_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (frame_len_reg),
        .wdata (s_tdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_valid_reg || m_tready;
    assign crc_result = crc_step(crc_reg, crc_operand);
    assign fld_count  = field_count(cur_kind_reg);
    assign fld_offset = AW'(word_offset(cur_kind_reg, idx_reg[3:0]));
    assign cfg_ready  = 1'b1;

    always_comb begin
        case (cur_kind_reg)
            MK_STATUS: kind_adv = MK_TEMPS;
            MK_TEMPS:  kind_adv = MK_CELLS;
            default:   kind_adv = MK_STATUS;
        endcase
    end

    always_comb begin
        case (idx_reg[2:0])
            TX_POS_SYNC0: tx_sel = SYNC_BYTE;
            TX_POS_START: tx_sel = start_byte_reg;
            TX_POS_DEV:   tx_sel = device_id_reg;
            TX_POS_ID:    tx_sel = id_reg;
            TX_POS_CRC:   tx_sel = crc_reg;
            TX_POS_END:   tx_sel = end_byte_reg;
            default:      tx_sel = SYNC_BYTE;
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == OP_SEND) begin
                        state_next = ST_TX_CRC0;
                    end else if (s_tdata == start_byte_reg) begin
                        state_next = ST_IDLE;
                    end else if (s_tdata == end_byte_reg) begin
                        if (in_frame_reg) begin
                            state_next = (frame_len_reg == '0) ? ST_ERR : ST_CK_RD;
                        end
                    end else if (in_frame_reg && frame_len_reg == AW'(BUFFER_DEPTH - 1)) begin
                        state_next = ST_ERR;
                    end
                end
            end
            ST_TX_CRC0: state_next = ST_TX_CRC1;
            ST_TX_CRC1: state_next = ST_TX_SEND;
            ST_TX_SEND: begin
                if (out_free && idx_reg[2:0] == TX_POS_SYNC1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_CK_RD: state_next = ST_CK_ACC;
            ST_CK_ACC: begin
                if (idx_reg == len_reg - AW'(1)) begin
                    state_next = (crc_reg == ram_rdata) ? ST_W_HI : ST_ERR;
                end else begin
                    state_next = ST_CK_RD;
                end
            end
            ST_W_HI:  state_next = ST_W_LO;
            ST_W_LO:  state_next = ST_W_CAP;
            ST_W_CAP: state_next = ST_W_SEND;
            ST_W_SEND: begin
                if (out_free) begin
                    state_next = (idx_reg[3:0] == fld_count - 4'd1) ? ST_IDLE : ST_W_HI;
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, buffer port and shared CRC operand.
    always_comb begin
        s_tready    = 1'b0;
        ram_we      = 1'b0;
        ram_raddr   = idx_reg;
        crc_operand = ram_rdata;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                ram_we   = accept && (s_tuser == OP_RX_BYTE) && in_frame_reg &&
                           (s_tdata != start_byte_reg) && (s_tdata != end_byte_reg);
            end
            ST_TX_CRC0: crc_operand = device_id_reg;
            ST_TX_CRC1: crc_operand = id_reg;
            ST_W_HI:    ram_raddr = fld_offset;
            ST_W_LO:    ram_raddr = fld_offset + AW'(1);
            default: begin
                ram_raddr = idx_reg;
            end
        endcase
    end

    // Datapath and result register.
    always_comb begin
        in_frame_next  = in_frame_reg;
        frame_len_next = frame_len_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        cur_kind_next  = cur_kind_reg;
        crc_next       = crc_reg;
        id_next        = id_reg;
        word_next      = word_reg;
        err_kind_next  = err_kind_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_kind_next    = m_kind_reg;
        m_tx_next      = m_tx_reg;
        m_msg_next     = m_msg_reg;
        m_idx_next     = m_idx_reg;
        m_val_next     = m_val_reg;
        m_last_next    = m_last_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == OP_SEND) begin
                        cur_kind_next = kind_adv;
                        case (kind_adv)
                            MK_STATUS: id_next = status_id_reg;
                            MK_TEMPS:  id_next = temp_id_reg;
                            default:   id_next = volt_id_reg;
                        endcase
                        crc_next = '0;
                        idx_next = '0;
                    end else if (s_tdata == start_byte_reg) begin
                        in_frame_next  = 1'b1;
                        frame_len_next = '0;
                    end else if (s_tdata == end_byte_reg) begin
                        if (in_frame_reg) begin
                            in_frame_next  = 1'b0;
                            frame_len_next = '0;
                            len_next       = frame_len_reg;
                            idx_next       = '0;
                            crc_next       = '0;
                            err_kind_next  = KIND_FRAME_ERR;
                        end
                    end else if (in_frame_reg) begin
                        if (frame_len_reg == AW'(BUFFER_DEPTH - 1)) begin
                            in_frame_next  = 1'b0;
                            frame_len_next = '0;
                            err_kind_next  = KIND_FRAME_ERR;
                        end else begin
                            frame_len_next = frame_len_reg + AW'(1);
                        end
                    end
                end
            end
            ST_TX_CRC0, ST_TX_CRC1: crc_next = crc_result;
            ST_TX_SEND: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_TX;
                    m_tx_next    = tx_sel;
                    m_msg_next   = cur_kind_reg;
                    m_idx_next   = '0;
                    m_val_next   = '0;
                    m_last_next  = (idx_reg[2:0] == TX_POS_SYNC1);
                    idx_next     = idx_reg + AW'(1);
                end
            end
            ST_CK_ACC: begin
                if (idx_reg == len_reg - AW'(1)) begin
                    idx_next      = '0;
                    err_kind_next = KIND_CRC_ERR;
                end else begin
                    crc_next = crc_result;
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_W_LO:  word_next[15:8] = ram_rdata;
            ST_W_CAP: word_next[7:0]  = ram_rdata;
            ST_W_SEND: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_WORD;
                    m_tx_next    = '0;
                    m_msg_next   = cur_kind_reg;
                    m_idx_next   = idx_reg[3:0];
                    m_val_next   = word_reg;
                    m_last_next  = (idx_reg[3:0] == fld_count - 4'd1);
                    idx_next     = idx_reg + AW'(1);
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = err_kind_reg;
                    m_tx_next    = '0;
                    m_msg_next   = cur_kind_reg;
                    m_idx_next   = '0;
                    m_val_next   = '0;
                    m_last_next  = 1'b1;
                end
            end
            default: begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            in_frame_reg   <= 1'b0;
            frame_len_reg  <= '0;
            cur_kind_reg   <= MK_STATUS;
            m_valid_reg    <= 1'b0;
            start_byte_reg <= START_BYTE_RST;
            end_byte_reg   <= END_BYTE_RST;
            device_id_reg  <= DEVICE_ID_RST;
            status_id_reg  <= STATUS_ID_RST;
            temp_id_reg    <= TEMP_ID_RST;
            volt_id_reg    <= VOLT_ID_RST;
        end else begin
            state_reg     <= state_next;
            in_frame_reg  <= in_frame_next;
            frame_len_reg <= frame_len_next;
            cur_kind_reg  <= cur_kind_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_START_BYTE: start_byte_reg <= cfg_data;
                    REG_END_BYTE:   end_byte_reg   <= cfg_data;
                    REG_DEVICE_ID:  device_id_reg  <= cfg_data;
                    REG_STATUS_ID:  status_id_reg  <= cfg_data;
                    REG_TEMP_ID:    temp_id_reg    <= cfg_data;
                    REG_VOLT_ID:    volt_id_reg    <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        len_reg      <= len_next;
        idx_reg      <= idx_next;
        crc_reg      <= crc_next;
        id_reg       <= id_next;
        word_reg     <= word_next;
        err_kind_reg <= err_kind_next;
        m_kind_reg   <= m_kind_next;
        m_tx_reg     <= m_tx_next;
        m_msg_reg    <= m_msg_next;
        m_idx_reg    <= m_idx_next;
        m_val_reg    <= m_val_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {2'b00, m_val_reg, m_idx_reg, m_msg_reg, m_tx_reg};

endmodule

`default_nettype wire

FILE: rtl/core/blft_ram.sv
`default_nettype none

module blft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/blft_checker.sv
`default_nettype none

module blft_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic [0:0]                       s_tuser,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [31:0]                      m_tdata,
    input wire logic [1:0]                       m_tuser,
    input wire logic                             m_tlast
);

    import blft_pkg::*;

    // A result that is held back must not disappear.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A send request keeps the sequencer busy for its CRC steps.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == OP_SEND |=> !s_tready)
        else $error("input accepted during frame transmit");

    // Only decoded words carry an index and a value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_WORD |-> m_tdata[29:10] == 20'd0)
        else $error("index or value set on a non-word result");

    // Error results are always the single, final result of their input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_CRC_ERR || m_tuser == KIND_FRAME_ERR) |-> m_tlast)
        else $error("error result not marked last");

    // Nothing leaves the block right after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind battery_link_frame_transceiver blft_checker u_blft_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

FILE: tb/battery_link_frame_transceiver_tb.sv
`default_nettype none

module battery_link_frame_transceiver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import blft_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx;
        logic [1:0]  msg;
        logic [3:0]  idx;
        logic [15:0] val;
        logic        last;
    } link_out_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;
    logic [0:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [31:0]            m_tdata;
    logic [1:0]             m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [7:0]             cfg_data;

    battery_link_frame_transceiver dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the link state and registers.
    logic [7:0] reg_start;
    logic [7:0] reg_end;
    logic [7:0] reg_dev;
    logic [7:0] reg_status;
    logic [7:0] reg_temp;
    logic [7:0] reg_volt;
    logic       in_frame;
    int         frame_len;
    logic [7:0] rx_store [32];
    logic [1:0] msg_kind;

    link_out_t  pending_link_out [$];
    link_out_t  due_out;
    link_out_t  seen_out;
    int         fault_count;
    int         items_sent;
    int         send_gap_pct;
    int         recv_gap_pct;
    int         hold_cycles;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("[battery_link_frame_transceiver] ERROR");
        $finish;
    end

    initial begin
        m_tready <= 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_out.kind = m_tuser;
            seen_out.tx   = m_tdata[7:0];
            seen_out.msg  = m_tdata[9:8];
            seen_out.idx  = m_tdata[13:10];
            seen_out.val  = m_tdata[29:14];
            seen_out.last = m_tlast;
            if (pending_link_out.size() == 0) begin
                $display("%0t: unexpected result kind=%0d tx=%02h msg=%0d idx=%0d val=%04h last=%0d",
                         $realtime, seen_out.kind, seen_out.tx, seen_out.msg, seen_out.idx,
                         seen_out.val, seen_out.last);
                fault_count++;
            end else begin
                due_out = pending_link_out.pop_front();
                if (seen_out.kind !== due_out.kind || seen_out.tx !== due_out.tx ||
                    seen_out.msg !== due_out.msg || seen_out.idx !== due_out.idx ||
                    seen_out.val !== due_out.val || seen_out.last !== due_out.last) begin
                    $display("%0t: mismatch expected kind=%0d tx=%02h msg=%0d idx=%0d val=%04h last=%0d",
                             $realtime, due_out.kind, due_out.tx, due_out.msg, due_out.idx,
                             due_out.val, due_out.last);
                    $display("%0t:          actual kind=%0d tx=%02h msg=%0d idx=%0d val=%04h last=%0d",
                             $realtime, seen_out.kind, seen_out.tx, seen_out.msg, seen_out.idx,
                             seen_out.val, seen_out.last);
                    fault_count++;
                end
            end
        end
    end

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] x;
        x = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            x = x[0] ? ((x >> 1) ^ 8'h8C) : (x >> 1);
        end
        return x;
    endfunction

    function automatic link_out_t make_out(input logic [1:0] k, input logic [7:0] tx,
                                           input logic [3:0] idx, input logic [15:0] val);
        link_out_t o;
        o.kind = k;
        o.tx   = tx;
        o.msg  = msg_kind;
        o.idx  = idx;
        o.val  = val;
        o.last = 1'b0;
        return o;
    endfunction

    function automatic logic [7:0] body_byte();
        logic [7:0] v;
        do begin
            v = 8'($urandom_range(0, 255));
        end while (v == reg_start || v == reg_end);
        return v;
    endfunction

    task automatic advance_link_model(input logic [0:0] op, input logic [7:0] b);
        link_out_t  burst [$];
        logic [7:0] frame_tx [7];
        logic [7:0] id;
        logic [7:0] crc;
        logic [4:0] temp_off [4];
        int         len;
        int         count;
        int         off;
        temp_off = '{5'd2, 5'd4, 5'd12, 5'd14};
        if (op == OP_SEND) begin
            msg_kind = (msg_kind >= MK_CELLS) ? MK_STATUS : msg_kind + 2'd1;
            case (msg_kind)
                MK_STATUS: id = reg_status;
                MK_TEMPS:  id = reg_temp;
                default:   id = reg_volt;
            endcase
            crc = crc8_step(crc8_step(8'h00, reg_dev), id);
            frame_tx = '{SYNC_BYTE, reg_start, reg_dev, id, crc, reg_end, SYNC_BYTE};
            foreach (frame_tx[i]) begin
                burst.push_back(make_out(KIND_TX, frame_tx[i], 4'd0, 16'd0));
            end
        end else if (b == reg_start) begin
            in_frame  = 1'b1;
            frame_len = 0;
        end else if (b == reg_end) begin
            if (in_frame) begin
                len       = frame_len;
                in_frame  = 1'b0;
                frame_len = 0;
                if (len == 0) begin
                    burst.push_back(make_out(KIND_FRAME_ERR, 8'd0, 4'd0, 16'd0));
                end else begin
                    crc = 8'h00;
                    for (int i = 0; i + 1 < len; i++) begin
                        crc = crc8_step(crc, rx_store[i]);
                    end
                    if (crc != rx_store[len-1]) begin
                        burst.push_back(make_out(KIND_CRC_ERR, 8'd0, 4'd0, 16'd0));
                    end else begin
                        count = (msg_kind == MK_TEMPS) ? 4 : (msg_kind == MK_CELLS) ? 7 : 13;
                        for (int i = 0; i < count; i++) begin
                            off = (msg_kind == MK_TEMPS) ? int'(temp_off[i]) : 2 + 2 * i;
                            burst.push_back(make_out(KIND_WORD, 8'd0, 4'(i),
                                                     {rx_store[off], rx_store[off+1]}));
                        end
                    end
                end
            end
        end else if (in_frame) begin
            if (frame_len < 32) begin
                rx_store[frame_len] = b;
            end
            frame_len++;
            if (frame_len >= 32) begin
                frame_len = 0;
                in_frame  = 1'b0;
                burst.push_back(make_out(KIND_FRAME_ERR, 8'd0, 4'd0, 16'd0));
            end
        end
        if (burst.size() > 0) begin
            burst[burst.size()-1].last = 1'b1;
        end
        foreach (burst[i]) begin
            pending_link_out.push_back(burst[i]);
        end
    endtask

    task automatic push_item(input logic [0:0] op, input logic [7:0] b);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        advance_link_model(op, b);
        items_sent++;
    endtask

    task automatic settle_link();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_link_out.size() != 0) begin
            @(posedge aclk);
        end
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        case (idx)
            REG_START_BYTE: reg_start  = val;
            REG_END_BYTE:   reg_end    = val;
            REG_DEVICE_ID:  reg_dev    = val;
            REG_STATUS_ID:  reg_status = val;
            REG_TEMP_ID:    reg_temp   = val;
            REG_VOLT_ID:    reg_volt   = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input logic [7:0] sb, input logic [7:0] eb, input logic [7:0] dv,
                                  input logic [7:0] st, input logic [7:0] tp, input logic [7:0] vt);
        settle_link();
        write_reg(REG_START_BYTE, sb);
        write_reg(REG_END_BYTE, eb);
        write_reg(REG_DEVICE_ID, dv);
        write_reg(REG_STATUS_ID, st);
        write_reg(REG_TEMP_ID, tp);
        write_reg(REG_VOLT_ID, vt);
    endtask

    task automatic send_frame(input int plen, input bit good);
        logic [7:0] body [$];
        logic [7:0] crc;
        int         tries;
        tries = 0;
        do begin
            body.delete();
            crc = 8'h00;
            for (int i = 0; i < plen; i++) begin
                body.push_back(body_byte());
                crc = crc8_step(crc, body[i]);
            end
            if (!good) begin
                crc = crc ^ 8'($urandom_range(1, 255));
            end
            tries++;
        end while ((crc == reg_start || crc == reg_end) && tries < 16);
        push_item(OP_RX_BYTE, reg_start);
        foreach (body[i]) begin
            push_item(OP_RX_BYTE, body[i]);
        end
        push_item(OP_RX_BYTE, crc);
        push_item(OP_RX_BYTE, reg_end);
    endtask

    task automatic overflow_frame(input bit with_extremes);
        push_item(OP_RX_BYTE, reg_start);
        if (with_extremes) begin
            push_item(OP_RX_BYTE, 8'h00);
            push_item(OP_RX_BYTE, 8'hFF);
            repeat (30) push_item(OP_RX_BYTE, body_byte());
        end else begin
            repeat (32) push_item(OP_RX_BYTE, body_byte());
        end
    endtask

    // The overflow frame also writes every buffer entry, so later short frames never read
    // an entry that was never written.
    task automatic test_overflow_fill();
        overflow_frame(1'b1);
    endtask

    task automatic test_framing_corners();
        push_item(OP_RX_BYTE, reg_end);
        push_item(OP_RX_BYTE, 8'h11);
        push_item(OP_RX_BYTE, reg_start);
        push_item(OP_RX_BYTE, reg_end);
        push_item(OP_RX_BYTE, reg_start);
        push_item(OP_RX_BYTE, 8'h22);
        send_frame(3, 1'b1);
        push_item(OP_RX_BYTE, reg_start);
        push_item(OP_RX_BYTE, 8'h00);
        push_item(OP_RX_BYTE, reg_end);
        send_frame(4, 1'b0);
    endtask

    task automatic test_request_frames();
        push_item(OP_SEND, 8'h00);
        send_frame(3, 1'b1);
        push_item(OP_SEND, 8'hFF);
        send_frame(2, 1'b1);
        push_item(OP_SEND, 8'($urandom_range(0, 255)));
        send_frame(3, 1'b1);
        push_item(OP_SEND, 8'($urandom_range(0, 255)));
    endtask

    task automatic exercise_setting();
        push_item(OP_SEND, 8'($urandom_range(0, 255)));
        send_frame($urandom_range(0, 6), 1'b1);
        send_frame(2, 1'b0);
        push_item(OP_RX_BYTE, reg_end);
        push_item(OP_SEND, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_register_settings();
        apply_settings(8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00);
        exercise_setting();
        apply_settings(8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF);
        exercise_setting();
        apply_settings(8'h55, 8'h55, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        push_item(OP_RX_BYTE, 8'h55);
        push_item(OP_RX_BYTE, 8'h01);
        push_item(OP_RX_BYTE, 8'h55);
        push_item(OP_RX_BYTE, 8'h02);
        push_item(OP_SEND, 8'h55);
        apply_settings(START_BYTE_RST, END_BYTE_RST, DEVICE_ID_RST, STATUS_ID_RST,
                       TEMP_ID_RST, VOLT_ID_RST);
        exercise_setting();
        apply_settings(8'h3C, 8'hC3, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        exercise_setting();
    endtask

    task automatic test_backpressure();
        send_gap_pct = 0;
        recv_gap_pct = 0;
        hold_cycles  = 600;
        send_frame(27, 1'b1);
        send_frame(27, 1'b1);
        push_item(OP_SEND, 8'($urandom_range(0, 255)));
        send_frame(15, 1'b1);
        push_item(OP_SEND, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int quota);
        int first;
        int pick;
        send_gap_pct = send_pct;
        recv_gap_pct = recv_pct;
        first = items_sent;
        while (items_sent - first < quota) begin
            pick = $urandom_range(0, 99);
            if (pick < 22) begin
                push_item(OP_SEND, 8'($urandom_range(0, 255)));
            end else if (pick < 72) begin
                send_frame(($urandom_range(0, 4) == 0) ? int'($urandom_range(27, 30))
                                                      : int'($urandom_range(0, 15)), 1'b1);
            end else if (pick < 82) begin
                send_frame($urandom_range(0, 15), 1'b0);
            end else if (pick < 88) begin
                push_item(OP_RX_BYTE, reg_start);
                repeat ($urandom_range(1, 3)) push_item(OP_RX_BYTE, body_byte());
                send_frame($urandom_range(0, 12), 1'b1);
            end else if (pick < 92) begin
                push_item(OP_RX_BYTE, reg_start);
                push_item(OP_RX_BYTE, reg_end);
            end else if (pick < 94) begin
                overflow_frame(1'b0);
            end else begin
                push_item(OP_RX_BYTE, reg_end);
                repeat ($urandom_range(1, 4)) push_item(OP_RX_BYTE, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        aresetn    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= 8'h00;
        s_tuser    <= OP_RX_BYTE;
        cfg_valid  <= 1'b0;
        cfg_index  <= REG_START_BYTE;
        cfg_data   <= 8'h00;
        reg_start  = START_BYTE_RST;
        reg_end    = END_BYTE_RST;
        reg_dev    = DEVICE_ID_RST;
        reg_status = STATUS_ID_RST;
        reg_temp   = TEMP_ID_RST;
        reg_volt   = VOLT_ID_RST;
        in_frame   = 1'b0;
        frame_len  = 0;
        msg_kind   = MK_STATUS;
        foreach (rx_store[i]) rx_store[i] = 8'h00;
        fault_count  = 0;
        items_sent   = 0;
        send_gap_pct = 0;
        recv_gap_pct = 30;
        hold_cycles  = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_overflow_fill();
        test_framing_corners();
        test_request_frames();
        test_register_settings();
        test_backpressure();
        test_random_traffic(21, 79, 60);
        test_random_traffic(79, 21, 60);
        test_random_traffic(0, 0, 60);

        settle_link();
        if (fault_count == 0 && pending_link_out.size() == 0) begin
            $display("[battery_link_frame_transceiver] OK");
        end else begin
            $display("[battery_link_frame_transceiver] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
